// ===== hdl/tsoi_pkg.sv =====
// Shared types and constants for the tag stack with ordered insert.
`timescale 1ns / 1ps

package tsoi_pkg;

  localparam int TAG_W           = 64;
  localparam int FUNC_W          = 3;
  localparam int MARK_W          = 5;
  localparam int STATUS_W        = 2;
  localparam int DEF_STACK_DEPTH = 16;

  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH    = 3'd0,
    FN_POP     = 3'd1,
    FN_POPMARK = 3'd2,
    FN_PEEK    = 3'd3,
    FN_INSERT  = 3'd4,
    FN_MEMBER  = 3'd5,
    FN_CLEAR   = 3'd6,
    FN_MARKTST = 3'd7
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_FULL       = 2'd1,
    ST_EMPTY_POP  = 2'd2,
    ST_UNUSED     = 2'd3
  } status_e;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic             cmp;   // register compare of each entry against tag
    logic             push;  // top-free cell loads tag
    logic             ins;   // ordered insert: shift up and load tag
    logic [TAG_W-1:0] tag;
  } cell_cmd_t;

endpackage

// ===== hdl/tsoi_cell.sv =====
// One entry of the tag stack: storage, compare flags and shift path to the neighbor above.
`timescale 1ns / 1ps

module tsoi_cell #(
  parameter int IDX = 0,
  parameter int CW  = 5
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tsoi_pkg::cell_cmd_t         cmd_i,
  input  logic [CW-1:0]               count_i,
  input  logic [tsoi_pkg::TAG_W-1:0]  below_entry_i,
  input  logic                        s_below_i,
  input  logic                        s_above_i,
  output logic [tsoi_pkg::TAG_W-1:0]  entry_o,
  output logic                        s_o,
  output logic                        hit_o,
  output logic                        dup_o,
  output logic [tsoi_pkg::TAG_W-1:0]  top_val_o
);
  import tsoi_pkg::*;

  logic [TAG_W-1:0] entry_q, entry_d;
  logic             le_q, le_d;
  logic             eq_q, eq_d;
  logic             valid;
  logic             is_free;
  logic             is_top;

  assign valid   = CW'(IDX) < count_i;
  assign is_free = CW'(IDX) == count_i;
  assign is_top  = (CW'(IDX) + CW'(1)) == count_i;

  assign entry_o   = entry_q;
  assign s_o       = le_q | s_above_i;
  assign hit_o     = eq_q;
  // The highest entry not above the tag decides a duplicate.
  assign dup_o     = le_q & eq_q & ~s_above_i;
  assign top_val_o = is_top ? entry_q : '0;

  always_comb begin
    entry_d = entry_q;
    if (cmd_i.push && is_free) begin
      entry_d = cmd_i.tag;
    end else if (cmd_i.ins && (valid || is_free) && !s_o) begin
      // At or above the insert point: take tag at the point, shift above it.
      entry_d = s_below_i ? cmd_i.tag : below_entry_i;
    end
  end

  always_comb begin
    le_d = le_q;
    eq_d = eq_q;
    if (cmd_i.cmp) begin
      le_d = valid && (entry_q <= cmd_i.tag);
      eq_d = valid && (entry_q == cmd_i.tag);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      le_q <= 1'b0;
      eq_q <= 1'b0;
    end else begin
      le_q <= le_d;
      eq_q <= eq_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

// ===== hdl/tag_stack_with_ordered_insert.sv =====
// Top level of the tag stack with ordered insert: control sequencer and chain of cells.
`timescale 1ns / 1ps

// A bounded stack of 64-bit tags held in a chain of cells, one entry per cell.
// Every transaction is accepted in the idle state: at the accept edge every cell
// compares its entry against the tag and registers the result; in the apply
// state the operation is applied (push, pop, ordered shift-up insert,
// membership, marks) and the result is written to the output register, held
// off while a waiting result is stalled at the output. A new transaction is
// taken only once the previous one has been applied. Entries are undefined
// until pushed or inserted; no clearing pass is needed after reset.
module tag_stack_with_ordered_insert #(
  parameter int STACK_DEPTH = tsoi_pkg::DEF_STACK_DEPTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [tsoi_pkg::FUNC_W-1:0]    func_i,
  input  logic [tsoi_pkg::TAG_W-1:0]     tag_value_i,
  input  logic [tsoi_pkg::MARK_W-1:0]    mark_depth_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [tsoi_pkg::TAG_W-1:0]     out_value_o,
  output logic                           flag_o,
  output logic [tsoi_pkg::MARK_W-1:0]    depth_now_o,
  output logic                           is_empty_o,
  output logic [tsoi_pkg::STATUS_W-1:0]  status_o
);
  import tsoi_pkg::*;

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int XW = (CW > MARK_W) ? CW : MARK_W;

  typedef enum logic {
    S_IDLE,
    S_APPLY
  } state_e;

  state_e            state_q;
  func_e             func_q;
  logic [TAG_W-1:0]  tag_q;
  logic [MARK_W-1:0] mark_q;
  logic [CW-1:0]     count_q, count_d;

  logic              out_valid_q;
  logic [TAG_W-1:0]  out_value_q, out_value_d;
  logic              flag_q, flag_d;
  logic [MARK_W-1:0] depth_q;
  logic              empty_q;
  status_e           status_q, status_d;

  logic      accept;
  logic      apply;
  logic      full;
  logic      empty;
  cell_cmd_t cmd;

  logic [TAG_W-1:0] entry    [STACK_DEPTH];
  logic             s_chain  [STACK_DEPTH+1];
  logic             hit_or   [STACK_DEPTH+1];
  logic             dup_or   [STACK_DEPTH+1];
  logic [TAG_W-1:0] top_or   [STACK_DEPTH+1];
  logic             hit      [STACK_DEPTH];
  logic             dup      [STACK_DEPTH];
  logic [TAG_W-1:0] top_val  [STACK_DEPTH];

  logic [XW-1:0] mark_x, count_x, count_dx;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign apply      = (state_q == S_APPLY) && (!out_valid_q || !out_stall_i);
  assign full       = (count_q == CW'(STACK_DEPTH));
  assign empty      = (count_q == '0);
  assign mark_x     = XW'(mark_q);
  assign count_x    = XW'(count_q);

  // Chains run top to bottom; the slot above the top cell contributes nothing.
  assign s_chain[STACK_DEPTH] = 1'b0;
  assign hit_or[STACK_DEPTH]  = 1'b0;
  assign dup_or[STACK_DEPTH]  = 1'b0;
  assign top_or[STACK_DEPTH]  = '0;

  for (genvar k = 0; k < STACK_DEPTH; k++) begin : g_cell
    logic [TAG_W-1:0] below;
    logic             s_below;
    if (k == 0) begin : g_bottom
      assign below   = cmd.tag;
      assign s_below = 1'b1;
    end else begin : g_upper
      assign below   = entry[k-1];
      assign s_below = s_chain[k-1];
    end

    tsoi_cell #(
      .IDX (k),
      .CW  (CW)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .cmd_i         (cmd),
      .count_i       (count_q),
      .below_entry_i (below),
      .s_below_i     (s_below),
      .s_above_i     (s_chain[k+1]),
      .entry_o       (entry[k]),
      .s_o           (s_chain[k]),
      .hit_o         (hit[k]),
      .dup_o         (dup[k]),
      .top_val_o     (top_val[k])
    );

    assign hit_or[k] = hit_or[k+1] | hit[k];
    assign dup_or[k] = dup_or[k+1] | dup[k];
    assign top_or[k] = top_or[k+1] | top_val[k];
  end

  always_comb begin
    cmd         = '0;
    cmd.cmp     = accept;
    cmd.tag     = accept ? tag_value_i : tag_q;
    count_d     = count_q;
    out_value_d = '0;
    flag_d      = 1'b0;
    status_d    = ST_OK;
    if (apply) begin
      case (func_q)
        FN_PUSH: begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            cmd.push = 1'b1;
            count_d  = count_q + CW'(1);
          end
        end
        FN_POP: begin
          if (empty) begin
            status_d = ST_EMPTY_POP;
          end else begin
            count_d     = count_q - CW'(1);
            out_value_d = top_or[0];
          end
        end
        FN_POPMARK: begin
          count_d = (mark_x > count_x) ? '0 : CW'(mark_x);
        end
        FN_PEEK: begin
          out_value_d = top_or[0];
        end
        FN_INSERT: begin
          if (dup_or[0]) begin
            flag_d = 1'b0;
          end else if (full) begin
            status_d = ST_FULL;
          end else begin
            cmd.ins = 1'b1;
            count_d = count_q + CW'(1);
            flag_d  = 1'b1;
          end
        end
        FN_MEMBER: begin
          flag_d = hit_or[0];
        end
        FN_CLEAR: begin
          count_d = '0;
        end
        FN_MARKTST: begin
          flag_d = (count_x == mark_x);
        end
        default: begin
          count_d = count_q;
        end
      endcase
    end
  end

  assign count_dx = XW'(count_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (apply) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= S_APPLY;
          end
        end
        S_APPLY: begin
          if (apply) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Payload registers: hold the transaction and the result.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= func_e'(func_i);
      tag_q  <= tag_value_i;
      mark_q <= mark_depth_i;
    end
    if (apply) begin
      out_value_q <= out_value_d;
      flag_q      <= flag_d;
      depth_q     <= count_dx[MARK_W-1:0];
      empty_q     <= (count_d == '0);
      status_q    <= status_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign flag_o      = flag_q;
  assign depth_now_o = depth_q;
  assign is_empty_o  = empty_q;
  assign status_o    = status_q;

endmodule

// ===== tb/tag_stack_with_ordered_insert_tb.sv =====
// Self-checking testbench for the tag stack with ordered insert.
`timescale 1ns / 1ps

module tag_stack_with_ordered_insert_tb;
  import tsoi_pkg::*;

  localparam int DEPTH          = DEF_STACK_DEPTH;
  localparam int IDLE_PCT       = 14;
  localparam int RANDOM_ITEMS   = 700;
  localparam int QUIET_FIRST    = 300;
  localparam int QUIET_LAST     = 430;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int MAX_PRINTED    = 40;

  typedef enum int {
    MODE_GROW,
    MODE_SHRINK,
    MODE_MIXED
  } burst_mode_e;

  typedef struct packed {
    logic [TAG_W-1:0]  value;
    logic              flag;
    logic [MARK_W-1:0] depth;
    logic              is_empty;
    status_e           status;
  } stack_result_t;

  // Shadow copy of the stack plus the queue of results still owed by the block.
  class tag_stack_scoreboard;
    logic [TAG_W-1:0] slots [DEPTH];
    int               fill;
    stack_result_t    owed_q [$];
    int unsigned      errors;
    int unsigned      checked;
    int unsigned      op_seen [8];
    int unsigned      full_refused;
    int unsigned      empty_refused;
    int unsigned      inserts_taken;
    int unsigned      dup_inserts;

    function new();
      fill          = 0;
      errors        = 0;
      checked       = 0;
      full_refused  = 0;
      empty_refused = 0;
      inserts_taken = 0;
      dup_inserts   = 0;
      foreach (op_seen[i]) op_seen[i] = 0;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    // Apply one accepted transaction to the shadow stack and queue its result.
    function void note_item(func_e f, logic [TAG_W-1:0] tag, logic [MARK_W-1:0] mark);
      stack_result_t r;
      int            pos;
      int            i;
      bit            dup;
      r.value    = '0;
      r.flag     = 1'b0;
      r.status   = ST_OK;
      op_seen[f]++;
      case (f)
        FN_PUSH: begin
          if (fill >= DEPTH) begin
            r.status = ST_FULL;
          end else begin
            slots[fill] = tag;
            fill++;
          end
        end
        FN_POP: begin
          if (fill == 0) begin
            r.status = ST_EMPTY_POP;
          end else begin
            fill--;
            r.value = slots[fill];
          end
        end
        FN_POPMARK: begin
          fill = (int'(mark) > fill) ? 0 : int'(mark);
        end
        FN_PEEK: begin
          if (fill != 0) r.value = slots[fill-1];
        end
        FN_INSERT: begin
          pos = 0;
          dup = 1'b0;
          // walk down from the top to the first entry not above the tag
          for (i = fill - 1; i >= 0; i--) begin
            if (slots[i] <= tag) begin
              dup = (slots[i] == tag);
              pos = i + 1;
              break;
            end
          end
          if (dup) begin
            dup_inserts++;
          end else if (fill >= DEPTH) begin
            r.status = ST_FULL;
          end else begin
            for (i = fill; i > pos; i--) slots[i] = slots[i-1];
            slots[pos] = tag;
            fill++;
            r.flag = 1'b1;
            inserts_taken++;
          end
        end
        FN_MEMBER: begin
          for (i = 0; i < fill; i++) begin
            if (slots[i] == tag) r.flag = 1'b1;
          end
        end
        FN_CLEAR: begin
          fill = 0;
        end
        default: begin
          r.flag = (fill == int'(mark));
        end
      endcase
      if (r.status == ST_FULL) full_refused++;
      if (r.status == ST_EMPTY_POP) empty_refused++;
      r.depth    = MARK_W'(fill);
      r.is_empty = (fill == 0);
      owed_q.push_back(r);
    endfunction

    task report_mismatch(string what);
      errors++;
      if (errors <= MAX_PRINTED) $display("[%0t] MISMATCH %s", $realtime, what);
    endtask

    task check_result(logic [TAG_W-1:0] value, logic flag, logic [MARK_W-1:0] depth,
                      logic is_empty, logic [STATUS_W-1:0] status);
      stack_result_t want;
      if (owed_q.size() == 0) begin
        report_mismatch($sformatf("result with no transaction pending, value %h", value));
        return;
      end
      want = owed_q.pop_front();
      checked++;
      if (value !== want.value)
        report_mismatch($sformatf("#%0d out_value %h, want %h", checked, value, want.value));
      if (flag !== want.flag)
        report_mismatch($sformatf("#%0d flag %b, want %b", checked, flag, want.flag));
      if (depth !== want.depth)
        report_mismatch($sformatf("#%0d depth_now %0d, want %0d", checked, depth, want.depth));
      if (is_empty !== want.is_empty)
        report_mismatch($sformatf("#%0d is_empty %b, want %b", checked, is_empty,
                                  want.is_empty));
      if (status !== want.status)
        report_mismatch($sformatf("#%0d status %0d, want %s", checked, status,
                                  want.status.name()));
    endtask
  endclass

  logic                clk          = 1'b0;
  logic                rst_ni       = 1'b0;
  logic                in_valid     = 1'b0;
  logic                in_stall;
  func_e               in_func      = FN_PUSH;
  logic [TAG_W-1:0]    in_tag       = '0;
  logic [MARK_W-1:0]   in_mark      = '0;
  logic                out_valid;
  logic                out_stall    = 1'b0;
  logic [TAG_W-1:0]    out_value;
  logic                out_flag;
  logic [MARK_W-1:0]   out_depth;
  logic                out_is_empty;
  logic [STATUS_W-1:0] out_status;

  bit                  in_taken     = 1'b0;
  bit                  quiet        = 1'b0;
  int                  idle_cycles  = 0;
  tag_stack_scoreboard sb;

  tag_stack_with_ordered_insert u_dut (
    .clk_i        (clk),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .func_i       (in_func),
    .tag_value_i  (in_tag),
    .mark_depth_i (in_mark),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .out_value_o  (out_value),
    .flag_o       (out_flag),
    .depth_now_o  (out_depth),
    .is_empty_o   (out_is_empty),
    .status_o     (out_status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Sample both channels at the rising edge; check results before noting new input.
  always @(posedge clk) begin
    bit out_taken;
    out_taken = rst_ni && out_valid && !out_stall;
    in_taken  = rst_ni && in_valid && !in_stall;
    if (out_taken) sb.check_result(out_value, out_flag, out_depth, out_is_empty, out_status);
    if (in_taken) sb.note_item(in_func, in_tag, in_mark);
    if (!rst_ni || in_taken || out_taken) idle_cycles = 0;
    else idle_cycles++;
  end

  always @(negedge clk) begin
    out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
  end

  initial begin : watchdog
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("[%0t] no transaction for %0d cycles", $realtime, WATCHDOG_LIMIT);
    $display("tag_stack_with_ordered_insert_tb: FAIL");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(func_e f, logic [TAG_W-1:0] tag, logic [MARK_W-1:0] mark);
    if (!quiet) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        in_valid = 1'b0;
        @(negedge clk);
      end
    end
    in_valid = 1'b1;
    in_func  = f;
    in_tag   = tag;
    in_mark  = mark;
    do @(negedge clk); while (!in_taken);
  endtask

  // Favor tags already held so that duplicates and member hits are common.
  function automatic logic [TAG_W-1:0] pick_tag();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35 && sb.fill > 0) return sb.slots[$urandom_range(0, sb.fill - 1)];
    if (r < 60) return TAG_W'($urandom_range(0, 31));
    if (r < 70) begin
      case ($urandom_range(0, 3))
        0:       return '0;
        1:       return '1;
        2:       return {1'b1, {(TAG_W-1){1'b0}}};
        default: return {{(TAG_W-1){1'b1}}, 1'b0};
      endcase
    end
    return {$urandom, $urandom};
  endfunction

  function automatic logic [MARK_W-1:0] pick_mark();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return MARK_W'(sb.fill);
    if (r < 65) return MARK_W'($urandom_range(0, sb.fill));
    return MARK_W'($urandom_range(0, DEPTH));
  endfunction

  function automatic func_e pick_func(burst_mode_e mode);
    int r;
    r = $urandom_range(0, 99);
    case (mode)
      MODE_GROW: begin
        if (r < 45) return FN_PUSH;
        if (r < 80) return FN_INSERT;
      end
      MODE_SHRINK: begin
        if (r < 30) return FN_POP;
        if (r < 50) return FN_POPMARK;
        if (r < 58) return FN_CLEAR;
      end
      default: ;
    endcase
    return func_e'($urandom_range(0, 7));
  endfunction

  initial begin : stimulus
    burst_mode_e mode;
    int          burst;
    int          n;
    int          k;
    sb = new();
    repeat (6) @(negedge clk);
    rst_ni = 1'b1;
    @(negedge clk);

    // directed: empty corners, extreme tags, ordered insert, marks
    send_item(FN_POP,     '0, '0);
    send_item(FN_PEEK,    '1, '0);
    send_item(FN_MARKTST, '0, 5'd0);
    send_item(FN_POPMARK, '0, 5'd16);
    send_item(FN_PUSH,    '1, '0);
    send_item(FN_PUSH,    '0, 5'd31);
    send_item(FN_PEEK,    '0, '0);
    send_item(FN_MEMBER,  '0, '0);
    send_item(FN_MEMBER,  64'd1, '0);
    send_item(FN_MARKTST, '0, 5'd2);
    send_item(FN_POP,     '0, '0);
    send_item(FN_CLEAR,   '0, '0);
    send_item(FN_INSERT,  64'h8000_0000_0000_0000, '0);
    send_item(FN_INSERT,  64'd5, '0);
    send_item(FN_INSERT,  '1, '0);
    send_item(FN_INSERT,  64'd5, '0);
    send_item(FN_INSERT,  64'h1234, '0);
    send_item(FN_INSERT,  '0, '0);
    send_item(FN_PEEK,    '0, '0);
    send_item(FN_POPMARK, '0, 5'd3);
    send_item(FN_POPMARK, '0, 5'd3);
    send_item(FN_POPMARK, '0, 5'd9);
    send_item(FN_MARKTST, '0, 5'd0);

    // random bursts; growth bursts run the stack into its full corners
    n = 0;
    while (n < RANDOM_ITEMS) begin
      mode  = (n == 0) ? MODE_GROW : burst_mode_e'($urandom_range(0, 2));
      burst = $urandom_range(8, 40);
      for (k = 0; k < burst && n < RANDOM_ITEMS; k++) begin
        quiet = (n >= QUIET_FIRST && n < QUIET_LAST);
        send_item(pick_func(mode), pick_tag(), pick_mark());
        n++;
      end
    end
    quiet    = 1'b0;
    in_valid = 1'b0;

    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("checked %0d transactions: push %0d pop %0d pop-to-mark %0d peek %0d insert %0d member %0d clear %0d mark-test %0d",
             sb.checked, sb.op_seen[FN_PUSH], sb.op_seen[FN_POP], sb.op_seen[FN_POPMARK],
             sb.op_seen[FN_PEEK], sb.op_seen[FN_INSERT], sb.op_seen[FN_MEMBER],
             sb.op_seen[FN_CLEAR], sb.op_seen[FN_MARKTST]);
    $display("full refusals %0d, empty pop refusals %0d, inserts taken %0d, duplicate inserts %0d",
             sb.full_refused, sb.empty_refused, sb.inserts_taken, sb.dup_inserts);
    if (sb.errors == 0) begin
      $display("tag_stack_with_ordered_insert_tb: PASS");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("tag_stack_with_ordered_insert_tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/tsoi_pkg.sv
hdl/tsoi_cell.sv
hdl/tag_stack_with_ordered_insert.sv
tb/tag_stack_with_ordered_insert_tb.sv
